// File: rtl/clt_pkg.sv
// Shared types, codes and defaults for the connection-tracking packet labeler.
// No dependencies; the other files of the block import it, all but clt_fifo.
package clt_pkg;

    // Protocol numbers seen in the IPv4 header.
    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
    localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

    // TCP flag patterns; all but RST are compared against the whole flags byte.
    localparam logic [7:0] FLAGS_SYN     = 8'h02;
    localparam logic [7:0] FLAGS_RST     = 8'h04;
    localparam logic [7:0] FLAGS_ACK     = 8'h10;
    localparam logic [7:0] FLAGS_SYN_ACK = FLAGS_SYN | FLAGS_ACK;

    // ICMP types with a rule of their own.
    localparam logic [7:0] ICMP_TYPE_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] ICMP_TYPE_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_TYPE_INFO_FIRST   = 8'd13;
    localparam logic [7:0] ICMP_TYPE_INFO_LAST    = 8'd18;

    // Stored connection states.
    localparam logic [3:0] ST_NEW        = 4'd0;
    localparam logic [3:0] ST_EST        = 4'd1;
    localparam logic [3:0] ST_SYN_SENT   = 4'd4;
    localparam logic [3:0] ST_SYN_RECV   = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT_1 = 4'd6;
    localparam logic [3:0] ST_FIN_WAIT_2 = 4'd7;
    localparam logic [3:0] ST_LAST_ACK   = 4'd8;
    localparam logic [3:0] ST_TIME_WAIT  = 4'd9;

    // Labels.
    localparam logic [1:0] LBL_NEW = 2'd0;
    localparam logic [1:0] LBL_EST = 2'd1;
    localparam logic [1:0] LBL_REL = 2'd2;
    localparam logic [1:0] LBL_INV = 2'd3;

    // Protocol classes decided by the front end.
    localparam logic [1:0] PCLASS_TCP   = 2'd0;
    localparam logic [1:0] PCLASS_UDP   = 2'd1;
    localparam logic [1:0] PCLASS_ICMP  = 2'd2;
    localparam logic [1:0] PCLASS_OTHER = 2'd3;

    // ICMP classes decided by the front end.
    localparam logic [1:0] ICLASS_ECHO_REQUEST = 2'd0;
    localparam logic [1:0] ICLASS_ECHO_REPLY   = 2'd1;
    localparam logic [1:0] ICLASS_INFO         = 2'd2;
    localparam logic [1:0] ICLASS_ERROR        = 2'd3;

    // Forwarding modes.
    localparam logic [1:0] MODE_CHAIN        = 2'd1;
    localparam logic [1:0] MODE_TABLE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_RESET        = MODE_CHAIN;

    // Next stage codes.
    localparam logic NEXT_CHAIN        = 1'b0;
    localparam logic NEXT_TABLE_UPDATE = 1'b1;

    // Default queue depths.
    localparam int MID_DEPTH_DEFAULT = 4;
    localparam int OUT_DEPTH_DEFAULT = 2;

    // Canonical key with its reversal bits.
    typedef struct packed {
        logic [31:0] low_address;
        logic [31:0] high_address;
        logic [15:0] low_port;
        logic [15:0] high_port;
        logic        address_reversed;
        logic        port_reversed;
    } key_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        key_t       key;
        logic [1:0] pclass;
        logic [1:0] iclass;
        logic       found;
        logic       fwd;
        logic       rev;
        logic       only_syn;
        logic       only_ack;
        logic       syn_ack;
        logic       rst;
        logic       ack_ok;
        logic [3:0] state;
    } front_item_t;

    // Finished result item.
    typedef struct packed {
        key_t       key;
        logic [1:0] label;
        logic       next_stage;
    } result_t;

endpackage

// File: rtl/clt_front.sv
// Front end of the labeler: canonical key ordering and classification of one item.
// Depends on clt_pkg.
module clt_front
(
    input  logic [31:0]              source_address,
    input  logic [31:0]              dest_address,
    input  logic [7:0]               protocol,
    input  logic [15:0]              source_port,
    input  logic [15:0]              dest_port,
    input  logic [7:0]               tcp_flag_bits,
    input  logic [31:0]              ack_number,
    input  logic [7:0]               icmp_kind,
    input  logic                     entry_found,
    input  logic [3:0]               entry_state,
    input  logic [1:0]               entry_direction,
    input  logic [31:0]              entry_sequence,
    output clt_pkg::front_item_t     item
);
    import clt_pkg::*;

    logic arev;
    logic prev;
    logic port_swap;

    always_comb
    begin
        arev      = source_address > dest_address;
        port_swap = source_port > dest_port;
        if (source_port < dest_port)
        begin
            prev = 1'b0;
        end
        else if (port_swap)
        begin
            prev = 1'b1;
        end
        else
        begin
            prev = arev;
        end

        item.key.low_address      = arev ? dest_address : source_address;
        item.key.high_address     = arev ? source_address : dest_address;
        item.key.low_port         = port_swap ? dest_port : source_port;
        item.key.high_port        = port_swap ? source_port : dest_port;
        item.key.address_reversed = arev;
        item.key.port_reversed    = prev;

        // A stored entry whose two bits disagree in kind is neither way round.
        item.fwd = (entry_direction[0] == arev) && (entry_direction[1] == prev);
        item.rev = (entry_direction[0] != arev) && (entry_direction[1] != prev);

        if (protocol == PROTO_NUM_TCP)
        begin
            item.pclass = PCLASS_TCP;
        end
        else if (protocol == PROTO_NUM_UDP)
        begin
            item.pclass = PCLASS_UDP;
        end
        else if (protocol == PROTO_NUM_ICMP)
        begin
            item.pclass = PCLASS_ICMP;
        end
        else
        begin
            item.pclass = PCLASS_OTHER;
        end

        if (icmp_kind == ICMP_TYPE_ECHO_REQUEST)
        begin
            item.iclass = ICLASS_ECHO_REQUEST;
        end
        else if (icmp_kind == ICMP_TYPE_ECHO_REPLY)
        begin
            item.iclass = ICLASS_ECHO_REPLY;
        end
        else if ((icmp_kind >= ICMP_TYPE_INFO_FIRST) && (icmp_kind <= ICMP_TYPE_INFO_LAST))
        begin
            item.iclass = ICLASS_INFO;
        end
        else
        begin
            item.iclass = ICLASS_ERROR;
        end

        item.found    = entry_found;
        item.only_syn = tcp_flag_bits == FLAGS_SYN;
        item.only_ack = tcp_flag_bits == FLAGS_ACK;
        item.syn_ack  = tcp_flag_bits == FLAGS_SYN_ACK;
        item.rst      = (tcp_flag_bits & FLAGS_RST) != 8'd0;
        item.ack_ok   = ack_number == entry_sequence;
        item.state    = entry_state;
    end

endmodule

// File: rtl/clt_fifo.sv
// Small first-in first-out queue of flat words, used between the pipeline parts.
// No dependencies.
module clt_fifo
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/clt_back.sv
// Back end of the labeler: label decision, forwarding mode register and next stage.
// Depends on clt_pkg.
module clt_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_data,
    input  clt_pkg::front_item_t  item,
    output clt_pkg::result_t      result
);
    import clt_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic [1:0] tcp_label;
    logic [1:0] udp_label;
    logic [1:0] icmp_label;
    logic [1:0] label;

    // The configuration channel is always ready, so valid alone writes.
    assign mode_next = cfg_valid ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        if (!item.found || (!item.fwd && !item.rev))
        begin
            tcp_label = item.only_syn ? LBL_NEW : LBL_INV;
        end
        else if (item.rst)
        begin
            tcp_label = LBL_EST;
        end
        else if (item.state == ST_SYN_SENT)
        begin
            if (item.fwd)
            begin
                tcp_label = item.only_syn ? LBL_NEW : LBL_INV;
            end
            else
            begin
                tcp_label = (item.syn_ack && item.ack_ok) ? LBL_EST : LBL_INV;
            end
        end
        else if (item.state == ST_SYN_RECV)
        begin
            if (item.fwd)
            begin
                tcp_label = (item.only_ack && item.ack_ok) ? LBL_EST : LBL_INV;
            end
            else
            begin
                tcp_label = (item.syn_ack && item.ack_ok) ? LBL_EST : LBL_INV;
            end
        end
        else if ((item.state == ST_EST) || (item.state == ST_FIN_WAIT_1) ||
                 (item.state == ST_FIN_WAIT_2) || (item.state == ST_LAST_ACK))
        begin
            tcp_label = LBL_EST;
        end
        else if ((item.state == ST_TIME_WAIT) && item.only_syn)
        begin
            tcp_label = LBL_NEW;
        end
        else
        begin
            tcp_label = LBL_INV;
        end

        if (item.found && item.fwd)
        begin
            udp_label = (item.state == ST_NEW) ? LBL_NEW : LBL_EST;
        end
        else if (item.found && item.rev)
        begin
            udp_label = LBL_EST;
        end
        else
        begin
            udp_label = LBL_NEW;
        end

        case (item.iclass)
            ICLASS_ECHO_REQUEST: icmp_label = LBL_NEW;
            ICLASS_ECHO_REPLY:   icmp_label = (item.found && item.rev) ? LBL_EST : LBL_INV;
            ICLASS_INFO:         icmp_label = LBL_INV;
            default:             icmp_label = item.found ? LBL_REL : LBL_INV;
        endcase

        case (item.pclass)
            PCLASS_TCP:  label = tcp_label;
            PCLASS_UDP:  label = udp_label;
            PCLASS_ICMP: label = icmp_label;
            default:     label = LBL_INV;
        endcase

        result.key        = item.key;
        result.label      = label;
        result.next_stage = ((mode_reg == MODE_TABLE_UPDATE) && (label == LBL_EST)) ?
                            NEXT_TABLE_UPDATE : NEXT_CHAIN;
    end

endmodule

// File: rtl/conntrack_packet_labeler.sv
// Top level of the connection-tracking packet labeler.
// Depends on clt_pkg, clt_front, clt_fifo and clt_back.
//
// Usage
// -----
// Input items arrive as a queue write: an item is taken at a rising edge with
// push high and full low. Each item carries parsed header fields and the
// result of an external connection-table lookup for its canonical key.
// Results leave as a queue read: while empty is low the oldest result is on
// the result ports, and it is taken at a rising edge with pop high.
// The front end orders the key and classifies the item in the cycle it is
// pushed; the item then waits in a queue of MID_DEPTH entries. The back end
// labels the head of that queue and writes it into an output queue of
// OUT_DEPTH entries whenever the output queue has room. One item per cycle
// is sustained while pop keeps up; the rate is set by the combinational
// label logic between the two queues.
// When the receiver stalls, the output queue fills first, then the middle
// queue, and full rises once MID_DEPTH + OUT_DEPTH results are held.
// The forwarding mode is written over its own channel (cfg_valid, cfg_ready,
// cfg_data); cfg_ready is always high and the write is registered.
// Reset empties both queues and sets the forwarding mode to always-chain.
module conntrack_packet_labeler
#(
    parameter int MID_DEPTH = clt_pkg::MID_DEPTH_DEFAULT,
    parameter int OUT_DEPTH = clt_pkg::OUT_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [7:0]  protocol,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [7:0]  tcp_flag_bits,
    input  logic [31:0] ack_number,
    input  logic [7:0]  icmp_kind,
    input  logic        entry_found,
    input  logic [3:0]  entry_state,
    input  logic [1:0]  entry_direction,
    input  logic [31:0] entry_sequence,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] low_address,
    output logic [31:0] high_address,
    output logic [15:0] low_port,
    output logic [15:0] high_port,
    output logic        address_reversed,
    output logic        port_reversed,
    output logic [1:0]  label,
    output logic        next_stage
);
    import clt_pkg::*;

    localparam int FRONT_W  = $bits(front_item_t);
    localparam int RESULT_W = $bits(result_t);

    front_item_t front_item;
    front_item_t mid_item;
    result_t     back_result;
    result_t     out_result;
    logic        mid_empty;
    logic        out_full;
    logic        move;

    assign cfg_ready = 1'b1;

    // Classify in the cycle of the push.
    clt_front u_front
    (
        .source_address  (source_address),
        .dest_address    (dest_address),
        .protocol        (protocol),
        .source_port     (source_port),
        .dest_port       (dest_port),
        .tcp_flag_bits   (tcp_flag_bits),
        .ack_number      (ack_number),
        .icmp_kind       (icmp_kind),
        .entry_found     (entry_found),
        .entry_state     (entry_state),
        .entry_direction (entry_direction),
        .entry_sequence  (entry_sequence),
        .item            (front_item)
    );

    // Queue between front and back ends.
    clt_fifo
    #(
        .DEPTH (MID_DEPTH),
        .WIDTH (FRONT_W)
    )
    u_mid_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (move),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    // The back end moves one item whenever there is one and room behind it.
    assign move = !mid_empty && !out_full;

    clt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .item      (mid_item),
        .result    (back_result)
    );

    // Output queue that the receiver reads.
    clt_fifo
    #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RESULT_W)
    )
    u_out_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (move),
        .wdata (back_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_result),
        .empty (empty)
    );

    assign low_address      = out_result.key.low_address;
    assign high_address     = out_result.key.high_address;
    assign low_port         = out_result.key.low_port;
    assign high_port        = out_result.key.high_port;
    assign address_reversed = out_result.key.address_reversed;
    assign port_reversed    = out_result.key.port_reversed;
    assign label            = out_result.label;
    assign next_stage       = out_result.next_stage;

endmodule

// File: rtl/clt_checker.sv
// Port-level checks for the connection-tracking packet labeler, and their binding.
// Depends on clt_pkg and conntrack_packet_labeler.
module clt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] low_address,
    input logic [31:0] high_address,
    input logic [15:0] low_port,
    input logic [15:0] high_port,
    input logic        address_reversed,
    input logic        port_reversed,
    input logic [1:0]  label,
    input logic        next_stage
);
    import clt_pkg::*;

    // No result is left over from before reset.
    a_empty_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result shown straight after reset");

    // The key on the result ports is always in canonical order.
    a_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (low_address <= high_address) && (low_port <= high_port))
        else $error("result key not in canonical order");

    // Equal addresses never count as reversed; equal ports copy the address bit.
    a_equal_keys: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((low_address != high_address) || !address_reversed) &&
                   ((low_port != high_port) || (port_reversed == address_reversed)))
        else $error("reversal bits inconsistent with equal key parts");

    // Only established packets are sent to the table update stage.
    a_next_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (next_stage == NEXT_TABLE_UPDATE)) |-> (label == LBL_EST))
        else $error("non-established packet routed to table update");

    // A result that is not taken stays available.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result vanished");

endmodule

bind conntrack_packet_labeler clt_checker u_clt_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (empty),
    .pop              (pop),
    .low_address      (low_address),
    .high_address     (high_address),
    .low_port         (low_port),
    .high_port        (high_port),
    .address_reversed (address_reversed),
    .port_reversed    (port_reversed),
    .label            (label),
    .next_stage       (next_stage)
);

// File: tb/clt_label_checker.sv
// Checker for the connection-tracking packet labeler: predicts each result item and compares it.
// Depends on clt_pkg for the key, result and code definitions.
`timescale 1ns / 100ps
module clt_label_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [7:0]  protocol,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [7:0]  tcp_flag_bits,
    input  logic [31:0] ack_number,
    input  logic [7:0]  icmp_kind,
    input  logic        entry_found,
    input  logic [3:0]  entry_state,
    input  logic [1:0]  entry_direction,
    input  logic [31:0] entry_sequence,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] low_address,
    input  logic [31:0] high_address,
    input  logic [15:0] low_port,
    input  logic [15:0] high_port,
    input  logic        address_reversed,
    input  logic        port_reversed,
    input  logic [1:0]  label,
    input  logic        next_stage,
    output int          error_count,
    output int          outstanding
);
    import clt_pkg::*;

    result_t    expected_labels[$];
    result_t    oldest;
    logic [1:0] mode_copy;

    function automatic logic [1:0] tcp_verdict(logic found, logic fwd, logic rev,
                                               logic [7:0] flags, logic [3:0] st,
                                               logic ack_ok);
        logic only_syn;
        only_syn = (flags == FLAGS_SYN);
        if (!found || (!fwd && !rev))
            return only_syn ? LBL_NEW : LBL_INV;
        if ((flags & FLAGS_RST) != 8'd0)
            return LBL_EST;
        case (st)
            ST_SYN_SENT:
                if (fwd)
                    return only_syn ? LBL_NEW : LBL_INV;
                else
                    return (flags == FLAGS_SYN_ACK && ack_ok) ? LBL_EST : LBL_INV;
            ST_SYN_RECV:
                if (fwd)
                    return (flags == FLAGS_ACK && ack_ok) ? LBL_EST : LBL_INV;
                else
                    return (flags == FLAGS_SYN_ACK && ack_ok) ? LBL_EST : LBL_INV;
            ST_EST, ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_LAST_ACK:
                return LBL_EST;
            ST_TIME_WAIT:
                return only_syn ? LBL_NEW : LBL_INV;
            default:
                return LBL_INV;
        endcase
    endfunction

    function automatic result_t label_packet(logic [31:0] sa, logic [31:0] da,
                                             logic [7:0] proto, logic [15:0] sp,
                                             logic [15:0] dp, logic [7:0] flags,
                                             logic [31:0] ackn, logic [7:0] kind,
                                             logic found, logic [3:0] st,
                                             logic [1:0] dir, logic [31:0] seq,
                                             logic [1:0] mode);
        result_t    r;
        logic       arev;
        logic       prev;
        logic       fwd;
        logic       rev;
        logic [1:0] lbl;
        arev = (sa > da);
        prev = (sp < dp) ? 1'b0 : ((sp > dp) ? 1'b1 : arev);
        r.key.low_address      = arev ? da : sa;
        r.key.high_address     = arev ? sa : da;
        r.key.low_port         = (sp > dp) ? dp : sp;
        r.key.high_port        = (sp > dp) ? sp : dp;
        r.key.address_reversed = arev;
        r.key.port_reversed    = prev;
        fwd = (dir[0] == arev) && (dir[1] == prev);
        rev = (dir[0] != arev) && (dir[1] != prev);
        if (proto == PROTO_NUM_TCP)
            lbl = tcp_verdict(found, fwd, rev, flags, st, ackn == seq);
        else if (proto == PROTO_NUM_UDP)
        begin
            if (found && fwd)
                lbl = (st == ST_NEW) ? LBL_NEW : LBL_EST;
            else if (found && rev)
                lbl = LBL_EST;
            else
                lbl = LBL_NEW;
        end
        else if (proto == PROTO_NUM_ICMP)
        begin
            if (kind == ICMP_TYPE_ECHO_REQUEST)
                lbl = LBL_NEW;
            else if (kind == ICMP_TYPE_ECHO_REPLY)
                lbl = (found && rev) ? LBL_EST : LBL_INV;
            else if (kind >= ICMP_TYPE_INFO_FIRST && kind <= ICMP_TYPE_INFO_LAST)
                lbl = LBL_INV;
            else
                lbl = found ? LBL_REL : LBL_INV;
        end
        else
            lbl = LBL_INV;
        r.label      = lbl;
        r.next_stage = (mode == MODE_TABLE_UPDATE && lbl == LBL_EST) ?
                       NEXT_TABLE_UPDATE : NEXT_CHAIN;
        return r;
    endfunction

    function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // The result side is checked before the input side so that a stray result item
    // at an edge where an item is also accepted is still caught.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_labels.delete();
            mode_copy   = MODE_RESET;
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_labels.size() == 0)
                begin
                    $display("%0t: result item with none expected, expected nothing, actual %0h",
                             $time, {low_address, high_address, low_port, high_port,
                                     address_reversed, port_reversed, label, next_stage});
                    error_count++;
                end
                else
                begin
                    oldest = expected_labels.pop_front();
                    error_count += field_differs("low_address", oldest.key.low_address,
                                                 low_address);
                    error_count += field_differs("high_address", oldest.key.high_address,
                                                 high_address);
                    error_count += field_differs("low_port", 32'(oldest.key.low_port),
                                                 32'(low_port));
                    error_count += field_differs("high_port", 32'(oldest.key.high_port),
                                                 32'(high_port));
                    error_count += field_differs("address_reversed",
                                                 32'(oldest.key.address_reversed),
                                                 32'(address_reversed));
                    error_count += field_differs("port_reversed",
                                                 32'(oldest.key.port_reversed),
                                                 32'(port_reversed));
                    error_count += field_differs("label", 32'(oldest.label), 32'(label));
                    error_count += field_differs("next_stage", 32'(oldest.next_stage),
                                                 32'(next_stage));
                end
            end
            if (push && !full)
                expected_labels.push_back(label_packet(source_address, dest_address, protocol,
                                                       source_port, dest_port, tcp_flag_bits,
                                                       ack_number, icmp_kind, entry_found,
                                                       entry_state, entry_direction,
                                                       entry_sequence, mode_copy));
            if (cfg_valid && cfg_ready)
                mode_copy = cfg_data;
            outstanding = expected_labels.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the testbench for the connection-tracking packet labeler: clock, reset and stimulus.
// Depends on clt_pkg, the block conntrack_packet_labeler and the checker clt_label_checker.
`timescale 1ns / 100ps
module tb_top;
    import clt_pkg::*;

    // Values that only the stimulus needs: an ICMP error type, protocols with no rule,
    // a stored state beyond the defined ones and the two mode values with no meaning.
    localparam logic [7:0] ICMP_TYPE_UNREACHABLE = 8'd3;
    localparam logic [7:0] PROTO_NUM_LOWEST      = 8'd0;
    localparam logic [7:0] PROTO_NUM_HIGHEST     = 8'd255;
    localparam logic [3:0] ST_TOP_UNUSED         = 4'd15;
    localparam logic [1:0] MODE_SPARE_LOW        = 2'd0;
    localparam logic [1:0] MODE_SPARE_HIGH       = 2'd3;

    // How the stored reversal bits relate to those of the packet.
    localparam int DIR_FORWARD = 0;
    localparam int DIR_REVERSE = 1;
    localparam int DIR_MIXED   = 2;

    localparam logic [31:0] ADDR_MIN = 32'h0000_0000;
    localparam logic [31:0] ADDR_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] PORT_MIN = 16'h0000;
    localparam logic [15:0] PORT_MAX = 16'hFFFF;

    localparam int IDLE_PERCENT = 28;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flag_bits;
        logic [31:0] ack_number;
        logic [7:0]  icmp_kind;
        logic        entry_found;
        logic [3:0]  entry_state;
        logic [1:0]  entry_direction;
        logic [31:0] entry_sequence;
    } packet_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data  = MODE_RESET;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    packet_t     pkt       = '0;
    logic        cfg_ready;
    logic        full;
    logic        empty;
    logic [31:0] low_address;
    logic [31:0] high_address;
    logic [15:0] low_port;
    logic [15:0] high_port;
    logic        address_reversed;
    logic        port_reversed;
    logic [1:0]  label;
    logic        next_stage;
    int          error_count;
    int          outstanding;
    int          idle_pct = IDLE_PERCENT;
    int          drain_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    conntrack_packet_labeler dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (full),
        .source_address   (pkt.source_address),
        .dest_address     (pkt.dest_address),
        .protocol         (pkt.protocol),
        .source_port      (pkt.source_port),
        .dest_port        (pkt.dest_port),
        .tcp_flag_bits    (pkt.tcp_flag_bits),
        .ack_number       (pkt.ack_number),
        .icmp_kind        (pkt.icmp_kind),
        .entry_found      (pkt.entry_found),
        .entry_state      (pkt.entry_state),
        .entry_direction  (pkt.entry_direction),
        .entry_sequence   (pkt.entry_sequence),
        .empty            (empty),
        .pop              (pop),
        .low_address      (low_address),
        .high_address     (high_address),
        .low_port         (low_port),
        .high_port        (high_port),
        .address_reversed (address_reversed),
        .port_reversed    (port_reversed),
        .label            (label),
        .next_stage       (next_stage)
    );

    clt_label_checker u_label_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .push             (push),
        .full             (full),
        .source_address   (pkt.source_address),
        .dest_address     (pkt.dest_address),
        .protocol         (pkt.protocol),
        .source_port      (pkt.source_port),
        .dest_port        (pkt.dest_port),
        .tcp_flag_bits    (pkt.tcp_flag_bits),
        .ack_number       (pkt.ack_number),
        .icmp_kind        (pkt.icmp_kind),
        .entry_found      (pkt.entry_found),
        .entry_state      (pkt.entry_state),
        .entry_direction  (pkt.entry_direction),
        .entry_sequence   (pkt.entry_sequence),
        .empty            (empty),
        .pop              (pop),
        .low_address      (low_address),
        .high_address     (high_address),
        .low_port         (low_port),
        .high_port        (high_port),
        .address_reversed (address_reversed),
        .port_reversed    (port_reversed),
        .label            (label),
        .next_stage       (next_stage),
        .error_count      (error_count),
        .outstanding      (outstanding)
    );

    // The receiver decides afresh at every falling edge whether it takes the next
    // result item, so stalls land on every phase of the block's queues.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= idle_pct);

    // Builds one packet. The stored direction is derived from the packet's own
    // reversal bits so that forward and reverse table hits are common; a mixed
    // entry keeps one bit and flips the other. The stored sequence either equals
    // the acknowledgement number or differs from it in a single bit.
    function automatic packet_t make_packet(logic [7:0] proto, logic [31:0] sa, logic [31:0] da,
                                            logic [15:0] sp, logic [15:0] dp,
                                            logic [7:0] flags, logic [7:0] kind,
                                            logic found, logic [3:0] st, int dir_sel,
                                            logic ack_ok);
        packet_t p;
        logic    arev;
        logic    prev;
        p.source_address = sa;
        p.dest_address   = da;
        p.protocol       = proto;
        p.source_port    = sp;
        p.dest_port      = dp;
        p.tcp_flag_bits  = flags;
        p.ack_number     = $urandom;
        p.icmp_kind      = kind;
        p.entry_found    = found;
        p.entry_state    = st;
        p.entry_sequence = ack_ok ? p.ack_number
                                  : p.ack_number ^ (32'd1 << $urandom_range(31));
        arev = (sa > da);
        prev = (sp < dp) ? 1'b0 : ((sp > dp) ? 1'b1 : arev);
        case (dir_sel)
            DIR_FORWARD: p.entry_direction = {prev, arev};
            DIR_REVERSE: p.entry_direction = {~prev, ~arev};
            default:     p.entry_direction = $urandom_range(1) ? {prev, ~arev} : {~prev, arev};
        endcase
        return p;
    endfunction

    // Most random packets are TCP, UDP or ICMP with meaningful flags, types and table
    // hits; the remainder is noise: other protocols, random flags, mixed entries and
    // stored states beyond the defined ones.
    function automatic packet_t random_packet();
        logic [7:0]  proto;
        logic [7:0]  flags;
        logic [7:0]  kind;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [3:0]  st;
        int          pick;
        int          dir_sel;
        pick = $urandom_range(99);
        if (pick < 32)
            proto = PROTO_NUM_TCP;
        else if (pick < 56)
            proto = PROTO_NUM_UDP;
        else if (pick < 80)
            proto = PROTO_NUM_ICMP;
        else
            proto = 8'($urandom);
        sa = $urandom;
        da = ($urandom_range(9) == 0) ? sa : $urandom;
        case ($urandom_range(15))
            0:       sa = ADDR_MIN;
            1:       da = ADDR_MAX;
            default: ;
        endcase
        sp = 16'($urandom);
        dp = ($urandom_range(7) == 0) ? sp : 16'($urandom);
        case ($urandom_range(7))
            0, 1:    flags = FLAGS_SYN;
            2:       flags = FLAGS_ACK;
            3:       flags = FLAGS_SYN_ACK;
            4:       flags = FLAGS_RST | 8'($urandom);
            default: flags = 8'($urandom);
        endcase
        case ($urandom_range(5))
            0:       kind = ICMP_TYPE_ECHO_REQUEST;
            1:       kind = ICMP_TYPE_ECHO_REPLY;
            2:       kind = 8'($urandom_range(ICMP_TYPE_INFO_FIRST, ICMP_TYPE_INFO_LAST));
            default: kind = 8'($urandom);
        endcase
        st = ($urandom_range(7) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
        dir_sel = ($urandom_range(9) < 8) ? $urandom_range(DIR_FORWARD, DIR_REVERSE)
                                          : DIR_MIXED;
        return make_packet(proto, sa, da, sp, dp, flags, kind, $urandom_range(9) != 0, st,
                           dir_sel, $urandom_range(99) < 65);
    endfunction

    // Called at a falling edge. The item is put on the ports after a random gap and
    // held until the block takes it; push is left high so that back-to-back items
    // see no bubble, and the next call or the caller lowers it.
    task automatic send_packet(input packet_t p);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        pkt  <= p;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The mode is only changed while the block is idle, once every expected result
    // item has been taken.
    task automatic set_mode(input logic [1:0] mode);
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_packet(random_packet());
    endtask

    // Directed packets: the field extremes, every TCP state rule, UDP answers, each
    // ICMP class, protocols with no rule, and equal ports copying the address reversal.
    task automatic send_directed();
        // Table misses, a mixed entry treated as a miss, and a reset flag.
        send_packet(make_packet(PROTO_NUM_TCP, ADDR_MIN, ADDR_MAX, PORT_MIN, PORT_MAX,
                                FLAGS_SYN, 8'd0, 1'b0, ST_NEW, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, ADDR_MAX, ADDR_MIN, PORT_MAX, PORT_MIN,
                                FLAGS_SYN_ACK, 8'd0, 1'b0, ST_EST, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'h0A00_0001, 32'h0A00_0002, 16'd1000, 16'd80,
                                FLAGS_SYN, 8'd0, 1'b1, ST_EST, DIR_MIXED, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'h0A00_0002, 32'h0A00_0001, 16'd80, 16'd1000,
                                FLAGS_RST | FLAGS_ACK, 8'd0, 1'b1, ST_SYN_SENT, DIR_FORWARD,
                                1'b0));
        // Opening handshake in both directions, with good and bad acknowledgements.
        send_packet(make_packet(PROTO_NUM_TCP, 32'hC0A8_0001, 32'hC0A8_0002, 16'd4000, 16'd443,
                                FLAGS_SYN, 8'd0, 1'b1, ST_SYN_SENT, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'hC0A8_0001, 32'hC0A8_0002, 16'd4000, 16'd443,
                                FLAGS_ACK, 8'd0, 1'b1, ST_SYN_SENT, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'hC0A8_0002, 32'hC0A8_0001, 16'd443, 16'd4000,
                                FLAGS_SYN_ACK, 8'd0, 1'b1, ST_SYN_SENT, DIR_REVERSE, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'hC0A8_0002, 32'hC0A8_0001, 16'd443, 16'd4000,
                                FLAGS_SYN_ACK, 8'd0, 1'b1, ST_SYN_SENT, DIR_REVERSE, 1'b0));
        send_packet(make_packet(PROTO_NUM_TCP, 32'hC0A8_0001, 32'hC0A8_0002, 16'd4000, 16'd443,
                                FLAGS_ACK, 8'd0, 1'b1, ST_SYN_RECV, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'hC0A8_0001, 32'hC0A8_0002, 16'd4000, 16'd443,
                                FLAGS_ACK, 8'd0, 1'b1, ST_SYN_RECV, DIR_FORWARD, 1'b0));
        send_packet(make_packet(PROTO_NUM_TCP, 32'hC0A8_0002, 32'hC0A8_0001, 16'd443, 16'd4000,
                                FLAGS_SYN_ACK, 8'd0, 1'b1, ST_SYN_RECV, DIR_REVERSE, 1'b1));
        // Open and closing states, a reused port after time-wait, and states with no rule.
        send_packet(make_packet(PROTO_NUM_TCP, 32'h1000_0000, 32'h2000_0000, 16'd22, 16'd5000,
                                FLAGS_ACK, 8'd0, 1'b1, ST_EST, DIR_FORWARD, 1'b0));
        send_packet(make_packet(PROTO_NUM_TCP, 32'h2000_0000, 32'h1000_0000, 16'd5000, 16'd22,
                                FLAGS_ACK, 8'd0, 1'b1, ST_LAST_ACK, DIR_REVERSE, 1'b0));
        send_packet(make_packet(PROTO_NUM_TCP, 32'h1000_0000, 32'h2000_0000, 16'd22, 16'd5000,
                                FLAGS_SYN, 8'd0, 1'b1, ST_TIME_WAIT, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'h1000_0000, 32'h2000_0000, 16'd22, 16'd5000,
                                FLAGS_ACK, 8'd0, 1'b1, ST_TIME_WAIT, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_TCP, 32'h1000_0000, 32'h2000_0000, 16'd22, 16'd5000,
                                FLAGS_ACK, 8'd0, 1'b1, ST_TOP_UNUSED, DIR_FORWARD, 1'b1));
        // UDP: equal ports copy the address reversal here.
        send_packet(make_packet(PROTO_NUM_UDP, 32'h0808_0808, 32'h0101_0101, 16'd53, 16'd53,
                                8'd0, 8'd0, 1'b1, ST_NEW, DIR_FORWARD, 1'b0));
        send_packet(make_packet(PROTO_NUM_UDP, 32'h0101_0101, 32'h0808_0808, 16'd53, 16'd53,
                                8'd0, 8'd0, 1'b1, ST_EST, DIR_FORWARD, 1'b0));
        send_packet(make_packet(PROTO_NUM_UDP, 32'h0808_0808, 32'h0101_0101, 16'd53, 16'd9000,
                                8'd0, 8'd0, 1'b1, ST_NEW, DIR_REVERSE, 1'b0));
        // ICMP: echo request, echo replies against reverse and forward entries, the
        // information types at both ends, and errors with and without a hit.
        send_packet(make_packet(PROTO_NUM_ICMP, ADDR_MAX, ADDR_MAX, PORT_MIN, PORT_MIN,
                                8'd0, ICMP_TYPE_ECHO_REQUEST, 1'b0, ST_NEW, DIR_FORWARD, 1'b0));
        send_packet(make_packet(PROTO_NUM_ICMP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd0, 16'd7,
                                8'd0, ICMP_TYPE_ECHO_REPLY, 1'b1, ST_EST, DIR_REVERSE, 1'b0));
        send_packet(make_packet(PROTO_NUM_ICMP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd0, 16'd7,
                                8'd0, ICMP_TYPE_ECHO_REPLY, 1'b1, ST_EST, DIR_FORWARD, 1'b0));
        send_packet(make_packet(PROTO_NUM_ICMP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd0, 16'd7,
                                8'd0, ICMP_TYPE_INFO_FIRST, 1'b1, ST_EST, DIR_REVERSE, 1'b0));
        send_packet(make_packet(PROTO_NUM_ICMP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd0, 16'd7,
                                8'd0, ICMP_TYPE_INFO_LAST, 1'b1, ST_EST, DIR_REVERSE, 1'b0));
        send_packet(make_packet(PROTO_NUM_ICMP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd0, 16'd7,
                                8'd0, ICMP_TYPE_UNREACHABLE, 1'b1, ST_EST, DIR_MIXED, 1'b0));
        send_packet(make_packet(PROTO_NUM_ICMP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd0, 16'd7,
                                8'd0, 8'hFF, 1'b0, ST_EST, DIR_MIXED, 1'b0));
        // Protocols with no rule at both ends of the byte.
        send_packet(make_packet(PROTO_NUM_LOWEST, 32'h1, 32'h2, 16'd1, 16'd2, FLAGS_SYN,
                                8'd0, 1'b1, ST_EST, DIR_FORWARD, 1'b1));
        send_packet(make_packet(PROTO_NUM_HIGHEST, 32'h2, 32'h1, 16'd2, 16'd1, FLAGS_SYN,
                                8'd0, 1'b1, ST_EST, DIR_REVERSE, 1'b1));
    endtask

    // Main sequence. Reset is held first, then the first phase runs at the reset
    // mode. Each later phase writes the mode and sends random items; the table
    // update mode carries the directed items and, in one phase, a stretch with no
    // idling on either side. Every mode value is visited, the spare ones included.
    initial
    begin
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_random(100);
        set_mode(MODE_TABLE_UPDATE);
        send_directed();
        send_random(150);
        set_mode(MODE_CHAIN);
        send_random(133);
        set_mode(MODE_SPARE_LOW);
        send_random(133);
        idle_pct = 0;
        set_mode(MODE_TABLE_UPDATE);
        send_random(133);
        idle_pct = IDLE_PERCENT;
        set_mode(MODE_SPARE_HIGH);
        send_random(133);
        set_mode(MODE_TABLE_UPDATE);
        send_random(133);
        set_mode(MODE_CHAIN);
        send_random(133);
        push <= 1'b0;

        // Drain: wait for every expected result item, then keep running so that any
        // surplus item the block might still emit is caught by the checker.
        drain_cycles = 0;
        while (outstanding != 0 && drain_cycles < 20000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        if (outstanding != 0)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            repeat (10)
                @(negedge clk);
            if (error_count == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
            $finish;
        end
    end

    // Watchdog: far beyond the slowest correct run with both sides stalling.
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/clt_pkg.sv
rtl/clt_front.sv
rtl/clt_fifo.sv
rtl/clt_back.sv
rtl/conntrack_packet_labeler.sv
rtl/clt_checker.sv
tb/clt_label_checker.sv
tb/tb_top.sv
